// ===== src/pcsd_pkg.sv =====
// Shared types, register codes and saturation helpers for the PID controller
// with settle detection. No dependencies; imported by every module of the block.
package pcsd_pkg;

  // Fixed Q16.16 data format
  localparam int DataW = 32;
  localparam int FracW = 16;

  // Configuration register indexes
  localparam logic [2:0] CFG_GAIN_P        = 3'd0;
  localparam logic [2:0] CFG_GAIN_I        = 3'd1;
  localparam logic [2:0] CFG_GAIN_D        = 3'd2;
  localparam logic [2:0] CFG_SAMPLE_RATE   = 3'd3;
  localparam logic [2:0] CFG_SAMPLE_PERIOD = 3'd4;
  localparam logic [2:0] CFG_MS_PER_SAMPLE = 3'd5;
  localparam logic [2:0] CFG_ERROR_BAND    = 3'd6;
  localparam logic [2:0] CFG_SETTLE_TIME   = 3'd7;

  // Register reset values
  localparam logic [19:0] RATE_RST   = 20'd1;
  localparam logic [31:0] PERIOD_RST = 32'h0001_0000;
  localparam logic [31:0] MS_RST     = 32'd65536000;

  // Request opcodes
  localparam logic OPC_UPDATE = 1'b0;
  localparam logic OPC_CLEAR  = 1'b1;

  // Saturation limits
  localparam logic [DataW-1:0] MAX_POS = {1'b0, {(DataW-1){1'b1}}};
  localparam logic [DataW-1:0] MAX_NEG = {1'b1, {(DataW-1){1'b0}}};

  typedef struct packed {
    logic                    opcode;
    logic signed [DataW-1:0] error_sample;
  } pcsd_in_t;

  typedef struct packed {
    logic signed [DataW-1:0] drive;
    logic signed [DataW-1:0] drive_change;
    logic                    stable;
  } pcsd_out_t;

  // Product selected for the shared multiplier
  typedef enum logic [2:0] {
    MOP_INT,  // (prev + err) * period, integral step
    MOP_DER,  // (err - prev) * rate
    MOP_P,    // gain_p * err
    MOP_IT,   // gain_i * integral
    MOP_DT,   // gain_d * derivative
    MOP_CLR   // integral * gain_i, removed from previous output
  } mul_op_e;

  // Controller to datapath commands
  typedef struct packed {
    logic    load_in;
    logic    issue;
    mul_op_e op;
    logic    fin;
    logic    load_out;
  } pcsd_cmd_t;

  // Saturate a 33-bit signed value to 32 bits
  function automatic logic signed [DataW-1:0] sat33(input logic signed [DataW:0] x);
    logic signed [DataW-1:0] r;
    if (x[DataW] != x[DataW-1]) begin
      r = x[DataW] ? MAX_NEG : MAX_POS;
    end else begin
      r = x[DataW-1:0];
    end
    return r;
  endfunction

  // Saturate a 34-bit signed value to 32 bits
  function automatic logic signed [DataW-1:0] sat34(input logic signed [DataW+1:0] x);
    logic signed [DataW-1:0] r;
    if ((x[DataW+1] != x[DataW]) || (x[DataW] != x[DataW-1])) begin
      r = x[DataW+1] ? MAX_NEG : MAX_POS;
    end else begin
      r = x[DataW-1:0];
    end
    return r;
  endfunction

endpackage

// ===== src/pcsd_ctrl.sv =====
// Sequencing state machine for the PID controller: steps the shared
// multiplier through the products of one request. Uses pcsd_pkg.
module pcsd_ctrl import pcsd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_opcode_i,
  output logic      in_stall_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output pcsd_cmd_t cmd_o
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_INT   = 4'd1;
  localparam logic [3:0] S_DER   = 4'd2;
  localparam logic [3:0] S_P     = 4'd3;
  localparam logic [3:0] S_IT    = 4'd4;
  localparam logic [3:0] S_DT    = 4'd5;
  localparam logic [3:0] S_POST  = 4'd6;
  localparam logic [3:0] S_FIN   = 4'd7;
  localparam logic [3:0] S_CLR   = 4'd8;
  localparam logic [3:0] S_CPOST = 4'd9;
  localparam logic [3:0] S_DONE  = 4'd10;

  logic [3:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '{load_in: 1'b0, issue: 1'b0, op: MOP_INT, fin: 1'b0, load_out: 1'b0};
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d = (in_opcode_i == OPC_CLEAR) ? S_CLR : S_INT;
        end
      end
      S_INT: begin
        cmd_o.issue = 1'b1;
        cmd_o.op    = MOP_INT;
        state_d     = S_DER;
      end
      S_DER: begin
        cmd_o.issue = 1'b1;
        cmd_o.op    = MOP_DER;
        state_d     = S_P;
      end
      S_P: begin
        cmd_o.issue = 1'b1;
        cmd_o.op    = MOP_P;
        state_d     = S_IT;
      end
      S_IT: begin
        cmd_o.issue = 1'b1;
        cmd_o.op    = MOP_IT;
        state_d     = S_DT;
      end
      S_DT: begin
        cmd_o.issue = 1'b1;
        cmd_o.op    = MOP_DT;
        state_d     = S_POST;
      end
      S_POST: begin
        state_d = S_FIN;
      end
      S_FIN: begin
        cmd_o.fin = 1'b1;
        state_d   = S_DONE;
      end
      S_CLR: begin
        cmd_o.issue = 1'b1;
        cmd_o.op    = MOP_CLR;
        state_d     = S_CPOST;
      end
      S_CPOST: begin
        state_d = S_DONE;
      end
      S_DONE: begin
        // wait for the output register to free up
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Output valid
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ===== src/pcsd_dp.sv =====
// Datapath of the PID controller: configuration registers, loop state, one
// shared 33x33 magnitude multiplier with round/saturate stage. Uses pcsd_pkg.
module pcsd_dp import pcsd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  input  pcsd_in_t    in_req_i,
  input  pcsd_cmd_t   cmd_i,
  output pcsd_out_t   out_req_o
);

  // Configuration
  logic signed [DataW-1:0] gain_p_q, gain_i_q, gain_d_q;
  logic [19:0]             rate_q;
  logic [31:0]             period_q, ms_q, settle_q;
  logic [DataW-2:0]        band_q;

  // Loop state
  logic signed [DataW-1:0] integ_q, integ_d;
  logic signed [DataW-1:0] prev_err_q, prev_err_d;
  logic signed [DataW-1:0] cur_q, cur_d;
  logic signed [DataW-1:0] prev_out_q, prev_out_d;
  logic [31:0]             timer_q, timer_d;
  logic                    flag_q, flag_d;

  // Working registers
  logic signed [DataW-1:0] err_q;
  logic signed [DataW-1:0] deriv_q, deriv_d;
  logic signed [DataW-1:0] pt_q, pt_d, it_q, it_d, dt_q, dt_d;
  logic [2*DataW+1:0]      prod_q;
  logic                    neg_q;
  mul_op_e                 pop_q;
  logic                    pvalid_q;
  pcsd_out_t               out_q;

  logic signed [DataW:0]   opa, opb;
  logic [DataW:0]          mag_a, mag_b;
  logic [2*DataW+2:0]      rnd, shifted;
  logic [DataW-1:0]        lim, mag_r;
  logic signed [DataW-1:0] res;
  logic [DataW-1:0]        emag;
  logic [32:0]             tsum;
  logic [31:0]             tnew;

  // Operand select for the shared multiplier
  always_comb begin
    opa = '0;
    opb = '0;
    case (cmd_i.op)
      MOP_INT: begin
        opa = {prev_err_q[DataW-1], prev_err_q} + {err_q[DataW-1], err_q};
        opb = {1'b0, period_q};
      end
      MOP_DER: begin
        opa = {err_q[DataW-1], err_q} - {prev_err_q[DataW-1], prev_err_q};
        opb = {13'd0, rate_q};
      end
      MOP_P: begin
        opa = {gain_p_q[DataW-1], gain_p_q};
        opb = {err_q[DataW-1], err_q};
      end
      MOP_IT: begin
        opa = {gain_i_q[DataW-1], gain_i_q};
        opb = {integ_q[DataW-1], integ_q};
      end
      MOP_DT: begin
        opa = {gain_d_q[DataW-1], gain_d_q};
        opb = {deriv_q[DataW-1], deriv_q};
      end
      MOP_CLR: begin
        opa = {integ_q[DataW-1], integ_q};
        opb = {gain_i_q[DataW-1], gain_i_q};
      end
      default: begin
        opa = '0;
        opb = '0;
      end
    endcase
  end

  // Sign-magnitude operands; the most negative 33-bit value maps to 2^32
  assign mag_a = opa[DataW] ? (~opa + 1'b1) : opa;
  assign mag_b = opb[DataW] ? (~opb + 1'b1) : opb;

  // Round half away from zero, shift (not MOP_DER), saturate prod_q
  always_comb begin
    rnd     = {1'b0, prod_q};
    shifted = rnd;
    case (pop_q)
      MOP_INT: begin
        rnd     = {1'b0, prod_q} + (67'd1 << FracW);
        shifted = rnd >> (FracW + 1);
      end
      MOP_DER: begin
        rnd     = {1'b0, prod_q};
        shifted = rnd;
      end
      default: begin
        rnd     = {1'b0, prod_q} + (67'd1 << (FracW - 1));
        shifted = rnd >> FracW;
      end
    endcase
    lim   = neg_q ? MAX_NEG : MAX_POS;
    mag_r = ((|shifted[2*DataW+2:DataW]) || (shifted[DataW-1:0] > lim))
            ? lim : shifted[DataW-1:0];
    res   = neg_q ? (~mag_r + 1'b1) : mag_r;
  end

  // Settle timer for the current sample
  assign emag = err_q[DataW-1] ? (~err_q + 1'b1) : err_q;
  assign tsum = {1'b0, timer_q} + {1'b0, ms_q};
  always_comb begin
    if (emag < {1'b0, band_q}) begin
      tnew = tsum[32] ? '1 : tsum[31:0];
    end else begin
      tnew = '0;
    end
  end

  // State updates from the post stage and the final step
  always_comb begin
    integ_d    = integ_q;
    prev_err_d = prev_err_q;
    cur_d      = cur_q;
    prev_out_d = prev_out_q;
    timer_d    = timer_q;
    flag_d     = flag_q;
    deriv_d    = deriv_q;
    pt_d       = pt_q;
    it_d       = it_q;
    dt_d       = dt_q;
    if (pvalid_q) begin
      case (pop_q)
        MOP_INT: integ_d = sat33({integ_q[DataW-1], integ_q} + {res[DataW-1], res});
        MOP_DER: deriv_d = res;
        MOP_P:   pt_d    = res;
        MOP_IT:  it_d    = res;
        MOP_DT:  dt_d    = res;
        MOP_CLR: begin
          prev_out_d = sat33({prev_out_q[DataW-1], prev_out_q} - {res[DataW-1], res});
          integ_d    = '0;
        end
        default: begin
          integ_d = integ_q;
        end
      endcase
    end
    if (cmd_i.fin) begin
      cur_d      = sat34({{2{pt_q[DataW-1]}}, pt_q} + {{2{it_q[DataW-1]}}, it_q}
                         + {{2{dt_q[DataW-1]}}, dt_q});
      prev_out_d = cur_q;
      prev_err_d = err_q;
      timer_d    = tnew;
      flag_d     = (settle_q != '0) && (settle_q <= tnew);
    end
  end

  // Configuration and loop state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_p_q   <= '0;
      gain_i_q   <= '0;
      gain_d_q   <= '0;
      rate_q     <= RATE_RST;
      period_q   <= PERIOD_RST;
      ms_q       <= MS_RST;
      band_q     <= '0;
      settle_q   <= '0;
      integ_q    <= '0;
      prev_err_q <= '0;
      cur_q      <= '0;
      prev_out_q <= '0;
      timer_q    <= '0;
      flag_q     <= 1'b0;
      pvalid_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_GAIN_P:        gain_p_q <= cfg_data_i;
          CFG_GAIN_I:        gain_i_q <= cfg_data_i;
          CFG_GAIN_D:        gain_d_q <= cfg_data_i;
          CFG_SAMPLE_RATE:   rate_q   <= cfg_data_i[19:0];
          CFG_SAMPLE_PERIOD: period_q <= cfg_data_i;
          CFG_MS_PER_SAMPLE: ms_q     <= cfg_data_i;
          CFG_ERROR_BAND:    band_q   <= cfg_data_i[DataW-2:0];
          CFG_SETTLE_TIME:   settle_q <= cfg_data_i;
          default:           settle_q <= settle_q;
        endcase
      end
      integ_q    <= integ_d;
      prev_err_q <= prev_err_d;
      cur_q      <= cur_d;
      prev_out_q <= prev_out_d;
      timer_q    <= timer_d;
      flag_q     <= flag_d;
      pvalid_q   <= cmd_i.issue;
    end
  end

  // Payload registers: sample, multiplier stage, terms, result
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      err_q <= in_req_i.error_sample;
    end
    if (cmd_i.issue) begin
      prod_q <= mag_a * mag_b;
      neg_q  <= opa[DataW] ^ opb[DataW];
      pop_q  <= cmd_i.op;
    end
    deriv_q <= deriv_d;
    pt_q    <= pt_d;
    it_q    <= it_d;
    dt_q    <= dt_d;
    if (cmd_i.load_out) begin
      out_q.drive        <= flag_q ? '0 : cur_q;
      out_q.drive_change <= sat33({cur_q[DataW-1], cur_q} - {prev_out_q[DataW-1], prev_out_q});
      out_q.stable       <= flag_q;
    end
  end

  assign out_req_o = out_q;

endmodule

// ===== src/pid_controller_stable_detect.sv =====
// Update request: the single shared 33x33 multiplier issues five products,
// one product per cycle (integral, derivative, P, I and D terms), followed by
// a round/saturate stage and the sum; then the result is registered and the
// next request is taken. Clear request: one product and the round/saturate stage.
// A waiting result does not block accept; the next result waits for it.
// rst_ni (async, active low) clears loop state and loads register defaults.
module pid_controller_stable_detect import pcsd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  pcsd_in_t    in_req_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output pcsd_out_t   out_req_o
);

  pcsd_cmd_t cmd;

  // Sequencer
  pcsd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_opcode_i (in_req_i.opcode),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  // Arithmetic and state
  pcsd_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_req_i   (in_req_i),
    .cmd_i      (cmd),
    .out_req_o  (out_req_o)
  );

endmodule

// ===== src/pcsd_checker.sv =====
// Port-level checks for pid_controller_stable_detect, bound to the top level.
// Uses pcsd_pkg for the request types.
module pcsd_checker import pcsd_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input pcsd_out_t   out_req_o
);

  // One request in flight: busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input not stalled after accept");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_req_o)))
    else $error("stalled result changed");

  // Drive is forced to zero while stable
  a_stable_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_req_o.stable) |-> (out_req_o.drive == '0))
    else $error("nonzero drive while stable");

  // A new result only appears at the end of a busy period
  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result without work");

endmodule

bind pid_controller_stable_detect pcsd_checker u_pcsd_checker (.*);

// ===== dv/pid_controller_stable_detect_tb.sv =====
// Self-checking testbench for pid_controller_stable_detect: random and directed
// update/clear requests checked against a fixed-point PID predictor.
// Depends on pcsd_pkg and the pid_controller_stable_detect RTL.
module pid_controller_stable_detect_tb;
  import pcsd_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_GAP   = 12;
  localparam int HOLD_CYCLES = 120;
  localparam int RAND_PHASES = 7;
  localparam int PHASE_ITEMS = 220;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [2:0]  cfg_idx_i;
  logic [31:0] cfg_data_i;
  logic        in_valid_i;
  logic        in_stall_o;
  pcsd_in_t    in_req_i;
  logic        out_valid_o;
  logic        out_stall_i;
  pcsd_out_t   out_req_o;

  pid_controller_stable_detect uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_req_o   (out_req_o)
  );

  // Fixed-point PID predictor and queue of expected drive results
  class pid_tracker;
    localparam longint QMAX = (longint'(1) <<< (DataW - 1)) - 1;
    localparam longint QMIN = -QMAX - 1;

    pcsd_out_t expected_drives[$];
    int mismatches;

    longint kp, ki, kd;
    longint unsigned rate, period, ms_step, band, settle;
    longint integ, last_err, out_now, out_last;
    longint unsigned timer;
    bit stable_now;

    function new();
      mismatches = 0;
      kp = 0;
      ki = 0;
      kd = 0;
      rate = 64'(RATE_RST);
      period = 64'(PERIOD_RST);
      ms_step = 64'(MS_RST);
      band = 0;
      settle = 0;
      integ = 0;
      last_err = 0;
      out_now = 0;
      out_last = 0;
      timer = 0;
      stable_now = 1'b0;
    endfunction

    function longint clamp(longint x);
      if (x > QMAX) return QMAX;
      if (x < QMIN) return QMIN;
      return x;
    endfunction

    // (a*b) >> sh, rounded half away from zero, saturated to DataW
    function longint mul_round(longint a, longint b, int sh);
      bit neg;
      logic [63:0] ua, ub, lim;
      logic [127:0] p;
      if (a == 0 || b == 0) return 0;
      neg = (a < 0) != (b < 0);
      ua = (a < 0) ? -a : a;
      ub = (b < 0) ? -b : b;
      p = {64'd0, ua} * {64'd0, ub};
      if (sh > 0) p = (p + (128'd1 << (sh - 1))) >> sh;
      lim = neg ? 64'(QMAX) + 64'd1 : 64'(QMAX);
      if (p > {64'd0, lim}) p = {64'd0, lim};
      return neg ? -longint'(p[63:0]) : longint'(p[63:0]);
    endfunction

    function void set_register(logic [2:0] idx, logic [31:0] v);
      case (idx)
        CFG_GAIN_P:        kp = longint'(signed'(v));
        CFG_GAIN_I:        ki = longint'(signed'(v));
        CFG_GAIN_D:        kd = longint'(signed'(v));
        CFG_SAMPLE_RATE:   rate = 64'(v[19:0]);
        CFG_SAMPLE_PERIOD: period = 64'(v);
        CFG_MS_PER_SAMPLE: ms_step = 64'(v);
        CFG_ERROR_BAND:    band = 64'(v[30:0]);
        CFG_SETTLE_TIME:   settle = 64'(v);
        default: ;
      endcase
    endfunction

    function void note_request(pcsd_in_t r);
      longint e, deriv, pt, it, dt;
      longint unsigned mag;
      pcsd_out_t res;
      if (r.opcode == OPC_CLEAR) begin
        // integral share leaves the stored previous output
        out_last = clamp(out_last - mul_round(integ, ki, FracW));
        integ = 0;
      end else begin
        e = longint'(r.error_sample);
        integ = clamp(integ + mul_round(last_err + e, longint'(period), FracW + 1));
        deriv = mul_round(e - last_err, longint'(rate), 0);
        pt = mul_round(kp, e, FracW);
        it = mul_round(ki, integ, FracW);
        dt = mul_round(kd, deriv, FracW);
        out_last = out_now;
        out_now = clamp(pt + it + dt);
        // settle timer saturates at all ones
        mag = (e < 0) ? -e : e;
        if (mag < band) begin
          timer = timer + ms_step;
          if (timer > 64'hFFFF_FFFF) timer = 64'hFFFF_FFFF;
        end else begin
          timer = 0;
        end
        stable_now = (settle != 0) && (settle <= timer);
        last_err = e;
      end
      res.drive = stable_now ? '0 : out_now[DataW-1:0];
      res.drive_change = 32'(clamp(out_now - out_last));
      res.stable = stable_now;
      expected_drives.push_back(res);
    endfunction

    function int outstanding();
      return expected_drives.size();
    endfunction

    function void check_result(pcsd_out_t got);
      pcsd_out_t want;
      if (expected_drives.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: drive %h change %h stable %b",
                   got.drive, got.drive_change, got.stable);
        return;
      end
      want = expected_drives.pop_front();
      if (got.drive !== want.drive || got.drive_change !== want.drive_change ||
          got.stable !== want.stable) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: drive exp %h got %h, change exp %h got %h, stable exp %b got %b",
                   want.drive, got.drive, want.drive_change, got.drive_change,
                   want.stable, got.stable);
      end
    endfunction
  endclass

  pid_tracker tracker = new();

  bit idle_on = 1'b1;
  bit hold_pending = 1'b0;
  longint err_walk = 0;

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("Regression FAIL");
    $finish;
  end

  // Result side: random stall bursts, plus one long hold-off on request
  initial begin
    forever begin
      if (hold_pending) begin
        hold_pending = 1'b0;
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 3)) @(posedge clk_i);
      end else begin
        out_stall_i <= 1'b0;
        @(posedge clk_i);
      end
    end
  end

  // Accepted requests feed the predictor, accepted results get checked
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) tracker.note_request(in_req_i);
      if (out_valid_o && !out_stall_i) tracker.check_result(out_req_o);
    end
  end

  // Offer one request, with an optional idle burst first
  task automatic send_request(pcsd_in_t r);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i <= r;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Wait until every expected result is back, then let the pipe settle
  task automatic drain();
    in_valid_i <= 1'b0;
    while (tracker.outstanding() != 0) @(posedge clk_i);
    repeat (DRAIN_GAP) @(posedge clk_i);
  endtask

  task automatic apply_settings(input logic [31:0] v [8]);
    drain();
    for (int i = 0; i < 8; i++) begin
      cfg_we_i <= 1'b1;
      cfg_idx_i <= 3'(i);
      cfg_data_i <= v[i];
      @(posedge clk_i);
      tracker.set_register(3'(i), v[i]);
    end
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic pcsd_in_t mk(logic opc, logic [31:0] e);
    pcsd_in_t r;
    r.opcode = opc;
    r.error_sample = e;
    return r;
  endfunction

  function automatic logic [31:0] random_gain();
    case ($urandom_range(0, 7))
      0: return $urandom;
      1: return MAX_POS;
      2: return MAX_NEG;
      default: return 32'($urandom_range(0, 32'h0004_0000)) - 32'h0002_0000;
    endcase
  endfunction

  task automatic random_settings();
    logic [31:0] v [8];
    longint unsigned settle_ms;
    v[CFG_GAIN_P] = random_gain();
    v[CFG_GAIN_I] = random_gain();
    v[CFG_GAIN_D] = random_gain();
    case ($urandom_range(0, 5))
      1: v[CFG_SAMPLE_RATE] = 32'd1000000;
      2: v[CFG_SAMPLE_RATE] = $urandom_range(1, 1000000);
      3: v[CFG_SAMPLE_RATE] = 32'd1;
      default: v[CFG_SAMPLE_RATE] = $urandom_range(1, 1000);
    endcase
    case ($urandom_range(0, 5))
      0: v[CFG_SAMPLE_PERIOD] = $urandom;
      1: v[CFG_SAMPLE_PERIOD] = '0;
      2: v[CFG_SAMPLE_PERIOD] = 32'hFFFF_FFFF;
      default: v[CFG_SAMPLE_PERIOD] = $urandom_range(1, 32'h0001_0000);
    endcase
    case ($urandom_range(0, 5))
      0: v[CFG_MS_PER_SAMPLE] = $urandom;
      1: v[CFG_MS_PER_SAMPLE] = 32'hFFFF_FFFF;
      2: v[CFG_MS_PER_SAMPLE] = '0;
      default: v[CFG_MS_PER_SAMPLE] = 32'h0001_0000 * $urandom_range(1, 10);
    endcase
    case ($urandom_range(0, 5))
      0: v[CFG_ERROR_BAND] = $urandom & 32'h7FFF_FFFF;
      1: v[CFG_ERROR_BAND] = 32'h7FFF_FFFF;
      2: v[CFG_ERROR_BAND] = '0;
      default: v[CFG_ERROR_BAND] = $urandom_range(32'h100, 32'h0002_0000);
    endcase
    // settle time in half of the draws one to six samples long so the flag gets reached
    case ($urandom_range(0, 5))
      0: v[CFG_SETTLE_TIME] = $urandom;
      1: v[CFG_SETTLE_TIME] = '0;
      2: v[CFG_SETTLE_TIME] = 32'hFFFF_FFFF;
      default: begin
        settle_ms = longint'(v[CFG_MS_PER_SAMPLE]) * $urandom_range(1, 6);
        if (settle_ms > 64'hFFFF_FFFF) settle_ms = 64'hFFFF_FFFF;
        v[CFG_SETTLE_TIME] = settle_ms[31:0];
      end
    endcase
    apply_settings(v);
  endtask

  // Mostly a decaying error walk that settles into the band, some noise and clears
  function automatic pcsd_in_t random_request();
    pcsd_in_t r;
    int pick;
    pick = $urandom_range(0, 31);
    r.opcode = (pick < 2) ? OPC_CLEAR : OPC_UPDATE;
    r.error_sample = $urandom;
    if (pick >= 5) begin
      if (pick < 7)
        err_walk = longint'($urandom_range(0, 32'h01FF_FFFF)) - 64'sd16777216;
      else
        err_walk = err_walk / 2 + longint'($urandom_range(0, 64)) - 32;
      r.error_sample = err_walk[31:0];
    end
    return r;
  endfunction

  initial begin
    logic [31:0] v [8];
    rst_ni <= 1'b0;
    cfg_we_i <= 1'b0;
    cfg_idx_i <= CFG_GAIN_P;
    cfg_data_i <= '0;
    in_valid_i <= 1'b0;
    in_req_i <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // register defaults straight out of reset
    send_request(mk(OPC_UPDATE, 32'h0000_0001));

    // moderate loop: extremes of the error, clear, settling into the band
    v[CFG_GAIN_P] = 32'h0001_0000;
    v[CFG_GAIN_I] = 32'h0000_8000;
    v[CFG_GAIN_D] = 32'h0000_0100;
    v[CFG_SAMPLE_RATE] = 32'd1000;
    v[CFG_SAMPLE_PERIOD] = 32'd66;
    v[CFG_MS_PER_SAMPLE] = 32'h0001_0000;
    v[CFG_ERROR_BAND] = 32'h0000_1000;
    v[CFG_SETTLE_TIME] = 32'h0003_0000;
    apply_settings(v);
    send_request(mk(OPC_UPDATE, 32'h7FFF_FFFF));
    send_request(mk(OPC_UPDATE, 32'h8000_0000));
    send_request(mk(OPC_UPDATE, 32'h0000_0000));
    send_request(mk(OPC_CLEAR, 32'hFFFF_FFFF));
    repeat (4) send_request(mk(OPC_UPDATE, 32'h0000_0100));
    send_request(mk(OPC_UPDATE, 32'hFFFF_FF00));
    send_request(mk(OPC_CLEAR, 32'h0000_0000));
    send_request(mk(OPC_UPDATE, 32'h0000_2000));

    // extreme gains and timing, zero rate, timer saturation at all ones
    v[CFG_GAIN_P] = MAX_NEG;
    v[CFG_GAIN_I] = MAX_POS;
    v[CFG_GAIN_D] = MAX_POS;
    v[CFG_SAMPLE_RATE] = '0;
    v[CFG_SAMPLE_PERIOD] = 32'hFFFF_FFFF;
    v[CFG_MS_PER_SAMPLE] = 32'hFFFF_FFFF;
    v[CFG_ERROR_BAND] = 32'h7FFF_FFFF;
    v[CFG_SETTLE_TIME] = 32'hFFFF_FFFF;
    apply_settings(v);
    send_request(mk(OPC_UPDATE, 32'h7FFF_FFFF));
    send_request(mk(OPC_UPDATE, 32'h8000_0000));
    send_request(mk(OPC_UPDATE, 32'h0000_0001));
    send_request(mk(OPC_UPDATE, 32'h0000_0001));
    send_request(mk(OPC_CLEAR, 32'h0000_0000));
    send_request(mk(OPC_UPDATE, 32'h8000_0000));

    // fastest rate, zero period, timer step and band, settle disabled
    v[CFG_GAIN_P] = MAX_POS;
    v[CFG_GAIN_I] = MAX_NEG;
    v[CFG_GAIN_D] = MAX_NEG;
    v[CFG_SAMPLE_RATE] = 32'd1000000;
    v[CFG_SAMPLE_PERIOD] = '0;
    v[CFG_MS_PER_SAMPLE] = '0;
    v[CFG_ERROR_BAND] = '0;
    v[CFG_SETTLE_TIME] = '0;
    apply_settings(v);
    send_request(mk(OPC_UPDATE, 32'h7FFF_FFFF));
    send_request(mk(OPC_UPDATE, 32'h8000_0000));
    send_request(mk(OPC_UPDATE, 32'h7FFF_FFFF));
    send_request(mk(OPC_CLEAR, 32'h7FFF_FFFF));

    // random phases, each under fresh settings; the last one without idling
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      random_settings();
      if (ph == RAND_PHASES - 1) idle_on = 1'b0;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (ph == 0 && n == 40) hold_pending = 1'b1;
        send_request(random_request());
      end
    end

    drain();
    if (tracker.mismatches == 0 && tracker.outstanding() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/pcsd_pkg.sv
src/pcsd_ctrl.sv
src/pcsd_dp.sv
src/pid_controller_stable_detect.sv
src/pcsd_checker.sv
dv/pid_controller_stable_detect_tb.sv
